FILE: sv/chiptune_square_noise_synth_defines.svh
// Assertion macros shared by the chiptune synthesiser RTL.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef CHIPTUNE_SQUARE_NOISE_SYNTH_DEFINES_SVH
`define CHIPTUNE_SQUARE_NOISE_SYNTH_DEFINES_SVH

// Condition b must hold in the same cycle as a.
`define CSNS_ASSERT_NOW(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error(msg);

// Condition b must hold in the cycle after a.
`define CSNS_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error(msg);

`endif

FILE: sv/csns_pkg.sv
// Shared types, constants and voice tables for the chiptune synthesiser.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package csns_pkg;

	// Voice counts and the fixed channel index width (three voices plus noise).
	localparam int TONE_VOICES_DEF = 3;
	localparam int MAX_TONE        = 3;
	localparam int CH_W            = 2;

	// Configuration register indexes.
	localparam logic [2:0] REG_GAIN  = 3'd0;
	localparam logic [2:0] REG_LEAD  = 3'd1;
	localparam logic [2:0] REG_BASS  = 3'd2;
	localparam logic [2:0] REG_ARP   = 3'd3;
	localparam logic [2:0] REG_SNARE = 3'd4;
	localparam logic [2:0] REG_HAT   = 3'd5;
	localparam logic [2:0] REG_MUTED = 3'd6;

	// Voice action codes; any other code retriggers.
	localparam logic [1:0] KIND_REST = 2'd0;
	localparam logic [1:0] KIND_TIE  = 2'd1;

	// Envelope and noise constants.
	localparam logic [16:0] ENV_FULL   = 17'd65536;
	localparam logic [16:0] HAT_START  = 17'd26000;
	localparam logic [16:0] SNARE_DEC  = 17'(65536 / 1500);
	localparam logic [16:0] HAT_DEC    = 17'(26000 / 330);
	localparam logic [15:0] LFSR_SEED  = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS  = 16'h6000;

	// Mixing and scaling widths.
	localparam int ACC_W = 26;
	localparam int MAG_W = 24;
	localparam int Q1_W  = 18;
	localparam int M2_W  = 25;
	localparam int Q2_W  = 19;

	// Reciprocals for exact division by 100 of values below 2**24 and 2**25.
	localparam int          DIV1_SH = 31;
	localparam logic [24:0] DIV1_K  = 25'd21474837;
	localparam int          DIV2_SH = 32;
	localparam logic [25:0] DIV2_K  = 26'd42949673;

	localparam logic [Q2_W-1:0] SAT_POS     = 19'd32767;
	localparam logic [Q2_W-1:0] SAT_NEG_MAG = 19'd32768;

	// Configuration register file as seen by the datapath.
	typedef struct packed {
		logic [6:0] gain;
		logic [6:0] lead_w;
		logic [6:0] bass_w;
		logic [6:0] arp_w;
		logic [6:0] snare_w;
		logic [6:0] hat_w;
		logic       muted;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            load;
		logic            clear_acc;
		logic            mul;
		logic            acc;
		logic            div1;
		logic            gain;
		logic            div2;
		logic            out_load;
		logic [CH_W-1:0] ch;
	} cmd_t;

	// Pulse duty of each voice, out of 256.
	function automatic logic [7:0] voice_duty(input logic [CH_W-1:0] v);
		case (v)
			2'd0:    voice_duty = 8'd128;
			2'd1:    voice_duty = 8'd64;
			2'd2:    voice_duty = 8'd32;
			default: voice_duty = 8'd0;
		endcase
	endfunction

	// Envelope floor of each voice.
	function automatic logic [16:0] voice_floor(input logic [CH_W-1:0] v);
		case (v)
			2'd0:    voice_floor = 17'd43000;
			2'd1:    voice_floor = 17'd52000;
			2'd2:    voice_floor = 17'd8000;
			default: voice_floor = 17'd0;
		endcase
	endfunction

	// Envelope decay per sample of each voice.
	function automatic logic [16:0] voice_decay(input logic [CH_W-1:0] v);
		case (v)
			2'd0:    voice_decay = 17'd120;
			2'd1:    voice_decay = 17'd110;
			2'd2:    voice_decay = 17'd520;
			default: voice_decay = 17'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: sv/csns_ctrl.sv
// Controller state machine of the chiptune synthesiser: sequences channels and scaling.
// Depends on csns_pkg for the command struct and channel index width.
`default_nettype none

module csns_ctrl #(
	parameter int TONE_VOICES = csns_pkg::TONE_VOICES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            op,
	input  logic            muted,
	output logic            out_valid,
	input  logic            out_ready,
	output csns_pkg::cmd_t  cmd
);
	import csns_pkg::*;

	localparam int NV = (TONE_VOICES > MAX_TONE) ? MAX_TONE : TONE_VOICES;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_DIV1 = 3'd3;
	localparam logic [2:0] S_GAIN = 3'd4;
	localparam logic [2:0] S_DIV2 = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]      state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d;
	logic            out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		cmd     = '0;
		cmd.ch  = ch_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!op) begin
						cmd.load = !muted;
					end else begin
						// A muted sample runs a zero mix through the scaling.
						cmd.clear_acc = 1'b1;
						ch_d          = '0;
						state_d       = muted ? S_DIV1 : S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (ch_q == CH_W'(NV)) begin
					state_d = S_DIV1;
				end else begin
					ch_d    = ch_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_DIV1: begin
				cmd.div1 = 1'b1;
				state_d  = S_GAIN;
			end
			S_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2 = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, channel counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/csns_dp.sv
// Datapath of the chiptune synthesiser: voice and noise state, mixer and output scaling.
// Depends on csns_pkg for tables, constants and the command and configuration structs.
`default_nettype none

module csns_dp #(
	parameter int TONE_VOICES = csns_pkg::TONE_VOICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csns_pkg::cmd_t      cmd,
	input  csns_pkg::cfg_t      cfg,
	input  logic [1:0]          lead_kind,
	input  logic [15:0]         lead_inc,
	input  logic [1:0]          bass_kind,
	input  logic [15:0]         bass_inc,
	input  logic [1:0]          arp_kind,
	input  logic [15:0]         arp_inc,
	input  logic                snare_hit,
	input  logic                hat_hit,
	output logic signed [15:0]  sample
);
	import csns_pkg::*;

	localparam int NV = (TONE_VOICES > MAX_TONE) ? MAX_TONE : TONE_VOICES;

	// Voice and noise state.
	logic [15:0] phase_q [NV];
	logic [15:0] inc_q   [NV];
	logic [16:0] env_q   [NV];
	logic [NV-1:0] active_q;
	logic [16:0] noise_env_q;
	logic        snare_q;
	logic [15:0] lfsr_q;

	// Per-voice inputs of a load transaction.
	logic [1:0]  kind_in [MAX_TONE];
	logic [15:0] inc_in  [MAX_TONE];

	// Next values for each channel.
	logic [NV-1:0] on;
	logic [NV-1:0] lvl_pos;
	logic [15:0]   phase_nx [NV];
	logic [16:0]   env_nx   [NV];
	logic [6:0]    voice_w  [NV];
	logic          noise_on;
	logic [15:0]   lfsr_nx;
	logic [16:0]   noise_dec;
	logic [16:0]   noise_env_nx;

	// Selected channel.
	logic        sel_on;
	logic        sel_pos;
	logic [8:0]  sel_hi;
	logic [6:0]  sel_w;

	// Mixer and scaling registers.
	logic [15:0]        prod_s1;
	logic               pos_s1;
	logic [ACC_W-1:0]   p_ext;
	logic [ACC_W-1:0]   term;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   mag_full;
	logic [MAG_W+24:0]  mul1;
	logic [M2_W+25:0]   mul2;
	logic               sign_q;
	logic [Q1_W-1:0]    q1_q;
	logic [M2_W-1:0]    m2_q;
	logic [Q2_W-1:0]    q2_q;
	logic [15:0]        sample_q;

	assign kind_in[0] = lead_kind;
	assign kind_in[1] = bass_kind;
	assign kind_in[2] = arp_kind;
	assign inc_in[0]  = lead_inc;
	assign inc_in[1]  = bass_inc;
	assign inc_in[2]  = arp_inc;

	// Phase advance, pulse level and envelope decay of each voice.
	always_comb begin
		for (int v = 0; v < NV; v++) begin
			on[v]       = active_q[v] && (inc_q[v] != 16'd0);
			phase_nx[v] = phase_q[v] + inc_q[v];
			lvl_pos[v]  = (phase_nx[v][15:8] < voice_duty(CH_W'(v)));
			if (env_q[v] > voice_floor(CH_W'(v))) begin
				if ((env_q[v] - voice_floor(CH_W'(v))) >= voice_decay(CH_W'(v))) begin
					env_nx[v] = env_q[v] - voice_decay(CH_W'(v));
				end else begin
					env_nx[v] = voice_floor(CH_W'(v));
				end
			end else begin
				env_nx[v] = env_q[v];
			end
			case (v)
				0:       voice_w[v] = cfg.lead_w;
				1:       voice_w[v] = cfg.bass_w;
				default: voice_w[v] = cfg.arp_w;
			endcase
		end
	end

	// Noise shift and decay towards zero.
	assign noise_on     = (noise_env_q != 17'd0);
	assign lfsr_nx      = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
	assign noise_dec    = snare_q ? SNARE_DEC : HAT_DEC;
	assign noise_env_nx = (noise_env_q > noise_dec) ? (noise_env_q - noise_dec) : 17'd0;

	// Channel select: the noise sits after the last voice.
	always_comb begin
		sel_on  = noise_on;
		sel_pos = lfsr_nx[0];
		sel_hi  = noise_env_q[16:8];
		sel_w   = snare_q ? cfg.snare_w : cfg.hat_w;
		for (int v = 0; v < NV; v++) begin
			if (cmd.ch == CH_W'(v)) begin
				sel_on  = on[v];
				sel_pos = lvl_pos[v];
				sel_hi  = env_q[v][16:8];
				sel_w   = voice_w[v];
			end
		end
	end

	// Voice and noise state updates for load transactions and channel steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NV; v++) begin
				phase_q[v] <= '0;
				inc_q[v]   <= '0;
				env_q[v]   <= '0;
			end
			active_q    <= '0;
			noise_env_q <= '0;
			snare_q     <= 1'b0;
			lfsr_q      <= LFSR_SEED;
		end else if (cmd.load) begin
			for (int v = 0; v < NV; v++) begin
				case (kind_in[v])
					KIND_REST: active_q[v] <= 1'b0;
					KIND_TIE:  active_q[v] <= 1'b1;
					default: begin
						inc_q[v]    <= inc_in[v];
						phase_q[v]  <= '0;
						env_q[v]    <= ENV_FULL;
						active_q[v] <= 1'b1;
					end
				endcase
			end
			// A snare hit wins over a hat hit.
			if (snare_hit) begin
				noise_env_q <= ENV_FULL;
				snare_q     <= 1'b1;
			end else if (hat_hit) begin
				noise_env_q <= HAT_START;
				snare_q     <= 1'b0;
			end
		end else if (cmd.mul) begin
			for (int v = 0; v < NV; v++) begin
				if (cmd.ch == CH_W'(v) && on[v]) begin
					phase_q[v] <= phase_nx[v];
					env_q[v]   <= env_nx[v];
				end
			end
			if (cmd.ch == CH_W'(NV) && noise_on) begin
				lfsr_q      <= lfsr_nx;
				noise_env_q <= noise_env_nx;
			end
		end
	end

	// Channel term: envelope times weight, then scaled by +127 or -128.
	assign p_ext = ACC_W'(prod_s1);
	assign term  = pos_s1 ? ((p_ext << 7) - p_ext) : (ACC_W'(0) - (p_ext << 7));

	// Magnitude of the mix and the two reciprocal multiplications.
	assign mag_full = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
	assign mul1     = (MAG_W+25)'(mag_full[MAG_W-1:0]) * (MAG_W+25)'(DIV1_K);
	assign mul2     = (M2_W+26)'(m2_q) * (M2_W+26)'(DIV2_K);

	// Mixer, division by 100, gain, division by 100 and saturation.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= sel_on ? (16'(sel_hi) * 16'(sel_w)) : 16'd0;
			pos_s1  <= sel_pos;
		end
		if (cmd.clear_acc) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + term;
		end
		if (cmd.div1) begin
			sign_q <= acc_q[ACC_W-1];
			q1_q   <= mul1[DIV1_SH +: Q1_W];
		end
		if (cmd.gain) begin
			m2_q <= M2_W'(q1_q) * M2_W'(cfg.gain);
		end
		if (cmd.div2) begin
			q2_q <= mul2[DIV2_SH +: Q2_W];
		end
		if (cmd.out_load) begin
			if (sign_q) begin
				sample_q <= (q2_q >= SAT_NEG_MAG) ? 16'h8000 : 16'(Q2_W'(0) - q2_q);
			end else begin
				sample_q <= (q2_q > SAT_POS) ? 16'h7FFF : q2_q[15:0];
			end
		end
	end

	assign sample = sample_q;

endmodule

`default_nettype wire

FILE: sv/chiptune_square_noise_synth.sv
// Chiptune synthesiser: pulse voices with duties 128, 64 and 32 of 256 plus one noise drum.
// Depends on csns_pkg, csns_ctrl, csns_dp and chiptune_square_noise_synth_defines.svh.
// Input channel (in_valid/in_ready): op 0 loads a score step (rest, tie or retrigger and
// a phase increment per voice, snare and hat hits); op 1 renders one sample.
// Output channel (out_valid/out_ready): one signed 16-bit sample per op 1 transaction,
// none for a load. Configuration channel (cfg_valid/cfg_ready): always ready, writes
// register cfg_index with cfg_data; write it only while the block is idle.
// Sequence: a load is accepted without leaving the idle state. For a sample, the mixer
// steps through each voice and the noise in a multiply and an accumulate step, then two
// reciprocal multiplies and the gain multiply scale the mix; a muted sample skips the
// mixer steps. The result is valid in the cycle after its output step.
// The finished sample sits in an output register, so a new transaction is accepted while
// it waits; when the receiver stalls, the next sample holds in its final step until the
// register is taken.
// Reset: configuration registers return to their reset values (muted set), phases,
// envelopes and increments clear, the noise register is seeded, and no result is pending.
`default_nettype none

module chiptune_square_noise_synth #(
	parameter int TONE_VOICES = csns_pkg::TONE_VOICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [1:0]         lead_kind,
	input  logic [15:0]        lead_inc,
	input  logic [1:0]         bass_kind,
	input  logic [15:0]        bass_inc,
	input  logic [1:0]         arp_kind,
	input  logic [15:0]        arp_inc,
	input  logic               snare_hit,
	input  logic               hat_hit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import csns_pkg::*;

	`include "chiptune_square_noise_synth_defines.svh"

	cfg_t cfg_q;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain    <= 7'd12;
			cfg_q.lead_w  <= 7'd42;
			cfg_q.bass_w  <= 7'd30;
			cfg_q.arp_w   <= 7'd16;
			cfg_q.snare_w <= 7'd20;
			cfg_q.hat_w   <= 7'd7;
			cfg_q.muted   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN:  cfg_q.gain    <= cfg_data;
				REG_LEAD:  cfg_q.lead_w  <= cfg_data;
				REG_BASS:  cfg_q.bass_w  <= cfg_data;
				REG_ARP:   cfg_q.arp_w   <= cfg_data;
				REG_SNARE: cfg_q.snare_w <= cfg_data;
				REG_HAT:   cfg_q.hat_w   <= cfg_data;
				REG_MUTED: cfg_q.muted   <= cfg_data[0];
				default:   cfg_q         <= cfg_q;
			endcase
		end
	end

	// Controller.
	csns_ctrl #(
		.TONE_VOICES(TONE_VOICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.muted     (cfg_q.muted),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath.
	csns_dp #(
		.TONE_VOICES(TONE_VOICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.lead_kind (lead_kind),
		.lead_inc  (lead_inc),
		.bass_kind (bass_kind),
		.bass_inc  (bass_inc),
		.arp_kind  (arp_kind),
		.arp_inc   (arp_inc),
		.snare_hit (snare_hit),
		.hat_hit   (hat_hit),
		.sample    (sample)
	);

	// A pending result is never overwritten.
	`CSNS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
	// A loaded result is presented in the next cycle.
	`CSNS_ASSERT_NEXT(a_out_shown, cmd.out_load, out_valid, "loaded result not presented")
	// Every channel multiply is followed by its accumulate.
	`CSNS_ASSERT_NEXT(a_mul_acc, cmd.mul, cmd.acc, "channel product not accumulated")
	// At most one datapath step runs in a cycle.
	`CSNS_ASSERT_NOW(a_one_step, 1'b1,
		$onehot0({cmd.mul, cmd.acc, cmd.div1, cmd.gain, cmd.div2, cmd.out_load}),
		"overlapping datapath steps")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the chiptune pulse and noise synthesiser.
// Depends on csns_pkg and the chiptune_square_noise_synth RTL; a directed step table
// is followed by randomised phases, each checked against a cycle-free behavioural model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csns_pkg::*;

	// Item codes and the kind codes that the package leaves unnamed.
	localparam logic       OP_LOAD   = 1'b0;
	localparam logic       OP_SAMPLE = 1'b1;
	localparam logic [1:0] KIND_TRIG = 2'd2;
	localparam logic [1:0] KIND_ALT  = 2'd3;
	localparam logic [2:0] REG_NONE  = 3'd7;

	// Voice shaping tables: duty out of 256, envelope floor and decay per sample.
	localparam int DUTY_TAB  [3] = '{128, 64, 32};
	localparam int FLOOR_TAB [3] = '{43000, 52000, 8000};
	localparam int DECAY_TAB [3] = '{120, 110, 520};

	// Settling time after draining, so that the block is idle before a write.
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES    = 7;
	localparam int PHASE_ITEMS    = 141;

	typedef struct packed {
		logic        op;
		logic [1:0]  lead_kind;
		logic [15:0] lead_inc;
		logic [1:0]  bass_kind;
		logic [15:0] bass_inc;
		logic [1:0]  arp_kind;
		logic [15:0] arp_inc;
		logic        snare_hit;
		logic        hat_hit;
	} synth_item_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed step table: either an item or a register write.
	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [6:0]  data;
		synth_item_t item;
		logic        known;
		logic [15:0] kval;
	} row_t;

	localparam synth_item_t RENDER = '{OP_SAMPLE, KIND_REST, 16'h0000, KIND_REST, 16'h0000,
		KIND_REST, 16'h0000, 1'b0, 1'b0};

	localparam int STEP_ROWS = 31;
	localparam row_t STEP_PLAN [STEP_ROWS] = '{
		// Straight after reset the block is muted.
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b1, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, '{OP_LOAD, KIND_TRIG, 16'h1234, KIND_TRIG, 16'h4321,
			KIND_TRIG, 16'h0101, 1'b1, 1'b0}, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b1, 16'd0},
		'{ROW_CFG, REG_MUTED, 7'd0, RENDER, 1'b0, 16'd0},
		// The muted load changed nothing, so every channel is still silent.
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b1, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, '{OP_LOAD, KIND_TRIG, 16'hFFFF, KIND_ALT, 16'h0001,
			KIND_TRIG, 16'h0000, 1'b1, 1'b1}, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, '{OP_LOAD, KIND_TIE, 16'h0000, KIND_TIE, 16'hFFFF,
			KIND_REST, 16'hFFFF, 1'b0, 1'b1}, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		// Everything at the top of its 7-bit range, weights beyond 100 included.
		'{ROW_CFG, REG_GAIN, 7'd127, RENDER, 1'b0, 16'd0},
		'{ROW_CFG, REG_LEAD, 7'd127, RENDER, 1'b0, 16'd0},
		'{ROW_CFG, REG_BASS, 7'd127, RENDER, 1'b0, 16'd0},
		'{ROW_CFG, REG_ARP, 7'd127, RENDER, 1'b0, 16'd0},
		'{ROW_CFG, REG_SNARE, 7'd127, RENDER, 1'b0, 16'd0},
		'{ROW_CFG, REG_HAT, 7'd127, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, '{OP_LOAD, KIND_TRIG, 16'h8000, KIND_TRIG, 16'h0100,
			KIND_TRIG, 16'h0080, 1'b1, 1'b0}, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		// Zero gain silences the output whatever the mix holds.
		'{ROW_CFG, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b1, 16'd0},
		// A write to the unused index must leave every register alone.
		'{ROW_CFG, REG_NONE, 7'h7F, RENDER, 1'b0, 16'd0},
		'{ROW_CFG, REG_GAIN, 7'd100, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, '{OP_LOAD, KIND_REST, 16'h0000, KIND_REST, 16'h0000,
			KIND_ALT, 16'h7FFF, 1'b0, 1'b0}, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0},
		// Muting again: the load is dropped and the sample is zero.
		'{ROW_CFG, REG_MUTED, 7'd1, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, '{OP_LOAD, KIND_TRIG, 16'h0400, KIND_TRIG, 16'h0200,
			KIND_TRIG, 16'h0800, 1'b0, 1'b1}, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b1, 16'd0},
		'{ROW_CFG, REG_MUTED, 7'd0, RENDER, 1'b0, 16'd0},
		'{ROW_ITEM, REG_GAIN, 7'd0, RENDER, 1'b0, 16'd0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = 1'b0;
	logic [1:0]         lead_kind = 2'd0;
	logic [15:0]        lead_inc = 16'd0;
	logic [1:0]         bass_kind = 2'd0;
	logic [15:0]        bass_inc = 16'd0;
	logic [1:0]         arp_kind = 2'd0;
	logic [15:0]        arp_inc = 16'd0;
	logic               snare_hit = 1'b0;
	logic               hat_hit = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] sample;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = 3'd0;
	logic [6:0]         cfg_data = 7'd0;

	chiptune_square_noise_synth u_dut (.*);

	// Model copy of the register file.
	logic [6:0] gain_pc, snare_w, hat_w;
	logic [6:0] mix_w [3];
	logic       mute;

	// Model copy of the voice and noise state.
	logic [15:0] ph [3];
	logic [15:0] incr [3];
	logic        act [3];
	int          env [3];
	int          noise_env;
	logic        noise_snare;
	logic [15:0] lfsr;

	logic [15:0] expected_samples [$];
	logic [15:0] want;
	int          fails = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	bit          idle_on = 1'b1;
	int          n_loads = 0, n_samples = 0, n_saturated = 0, n_writes = 0;

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, sometimes a few cycles, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [1:0] rand_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return KIND_REST;
		if (r < 50) return KIND_TIE;
		if (r < 90) return KIND_TRIG;
		return KIND_ALT;
	endfunction

	function automatic logic [15:0] rand_inc();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'h0000;
		if (r < 20) return 16'hFFFF;
		if (r < 25) return 16'h0001;
		if (r < 30) return 16'h8000;
		if (r < 65) return 16'($urandom_range(1, 16'h0800));
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// A register value for a random phase; phase 1 is all maximum, phase 2 all zero.
	function automatic logic [6:0] pick_setting(input int phase);
		int r;
		if (phase == 1) return 7'd127;
		if (phase == 2) return 7'd0;
		r = $urandom_range(0, 99);
		if (r < 15) return 7'd0;
		if (r < 30) return 7'd100;
		if (r < 45) return 7'd127;
		return 7'($urandom_range(0, 127));
	endfunction

	// Model: put the registers and the voices back to their reset state.
	function automatic void reset_model();
		int v;
		gain_pc = 7'd12;
		mix_w[0] = 7'd42;
		mix_w[1] = 7'd30;
		mix_w[2] = 7'd16;
		snare_w = 7'd20;
		hat_w = 7'd7;
		mute = 1'b1;
		for (v = 0; v < 3; v++) begin
			ph[v] = 16'd0;
			incr[v] = 16'd0;
			act[v] = 1'b0;
			env[v] = 0;
		end
		noise_env = 0;
		noise_snare = 1'b0;
		lfsr = LFSR_SEED;
	endfunction

	// Model: one register write; the unused index is dropped.
	function automatic void apply_reg(input logic [2:0] idx, input logic [6:0] val);
		case (idx)
			REG_GAIN:  gain_pc = val;
			REG_LEAD:  mix_w[0] = val;
			REG_BASS:  mix_w[1] = val;
			REG_ARP:   mix_w[2] = val;
			REG_SNARE: snare_w = val;
			REG_HAT:   hat_w = val;
			REG_MUTED: mute = val[0];
			default:   ;
		endcase
	endfunction

	// Model: rest silences a voice, tie keeps it going, any other code restarts it.
	function automatic void load_voice(input int v, input logic [1:0] kind,
		input logic [15:0] inc);
		if (kind == KIND_REST) begin
			act[v] = 1'b0;
			return;
		end
		if (kind != KIND_TIE) begin
			incr[v] = inc;
			ph[v] = 16'd0;
			env[v] = int'(ENV_FULL);
		end
		act[v] = 1'b1;
	endfunction

	// Model: a load transaction sets up one score step; the snare wins over the hat.
	function automatic void apply_step(input synth_item_t it);
		if (mute) return;
		load_voice(0, it.lead_kind, it.lead_inc);
		load_voice(1, it.bass_kind, it.bass_inc);
		load_voice(2, it.arp_kind, it.arp_inc);
		if (it.snare_hit) begin
			noise_env = int'(ENV_FULL);
			noise_snare = 1'b1;
		end else if (it.hat_hit) begin
			noise_env = int'(HAT_START);
			noise_snare = 1'b0;
		end
	endfunction

	// Model: step each sounding channel one sample, mix, scale and saturate; zero if muted.
	function automatic logic [15:0] render_sample();
		int v, lvl, wt, mix;
		if (mute) return 16'd0;
		mix = 0;
		for (v = 0; v < 3; v++) begin
			if (!act[v] || incr[v] == 16'd0) continue;
			ph[v] = ph[v] + incr[v];
			lvl = (ph[v][15:8] < DUTY_TAB[v]) ? 127 : -128;
			wt = mix_w[v];
			mix += lvl * (env[v] / 256) * wt;
			if (env[v] > FLOOR_TAB[v]) begin
				env[v] -= DECAY_TAB[v];
				if (env[v] < FLOOR_TAB[v]) env[v] = FLOOR_TAB[v];
			end
		end
		if (noise_env > 0) begin
			wt = noise_snare ? snare_w : hat_w;
			lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
			lvl = lfsr[0] ? 127 : -128;
			mix += lvl * (noise_env / 256) * wt;
			noise_env -= noise_snare ? int'(SNARE_DEC) : int'(HAT_DEC);
			if (noise_env < 0) noise_env = 0;
		end
		mix = mix / 100;
		mix = mix * int'(gain_pc) / 100;
		if (mix > 32767) begin
			mix = 32767;
			n_saturated++;
		end else if (mix < -32768) begin
			mix = -32768;
			n_saturated++;
		end
		return mix[15:0];
	endfunction

	// Offer one item and hold it until the transaction completes; then update the model.
	task automatic send_item(input synth_item_t it, input bit known,
		input logic [15:0] kval);
		logic [15:0] pred;
		in_valid <= 1'b1;
		op <= it.op;
		lead_kind <= it.lead_kind;
		lead_inc <= it.lead_inc;
		bass_kind <= it.bass_kind;
		bass_inc <= it.bass_inc;
		arp_kind <= it.arp_kind;
		arp_inc <= it.arp_inc;
		snare_hit <= it.snare_hit;
		hat_hit <= it.hat_hit;
		do @(posedge clk); while (!in_ready);
		if (it.op == OP_SAMPLE) begin
			pred = render_sample();
			expected_samples.push_back(known ? kval : pred);
			n_samples++;
		end else begin
			apply_step(it);
			n_loads++;
		end
	endtask

	// Random gap on the input side after a transaction.
	task automatic pause_input();
		int g;
		g = idle_on ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding sample, optionally letting a load finish.
	task automatic drain_results(input bit settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_samples.size() != 0);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write transaction; the caller lowers cfg_valid after the last one.
	task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		n_writes++;
	endtask

	// Output side: check each sample and stall at random.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample: nothing expected, actual %0d", sample);
				fails++;
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want) begin
					$error("sample: expected %0d, actual %0d", $signed(want), sample);
					fails++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 99) < 30) hold_left = pick_gap();
		end
	end

	// Watchdog: too long without any transaction on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: directed step table, then randomised phases with fresh settings.
	initial begin
		synth_item_t it;
		bit          cfg_open;
		int          done_items;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_open = 1'b0;
		for (int r = 0; r < STEP_ROWS; r++) begin
			if (STEP_PLAN[r].kind == ROW_CFG) begin
				if (!cfg_open) drain_results(1'b1);
				cfg_open = 1'b1;
				write_reg(STEP_PLAN[r].idx, STEP_PLAN[r].data);
			end else begin
				if (cfg_open) cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				send_item(STEP_PLAN[r].item, STEP_PLAN[r].known, STEP_PLAN[r].kval);
				pause_input();
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_results(1'b1);
			idle_on = (p % 3) != 2;
			write_reg(REG_GAIN, (p == 2) ? 7'd100 : pick_setting(p));
			write_reg(REG_LEAD, pick_setting(p));
			write_reg(REG_BASS, pick_setting(p));
			write_reg(REG_ARP, pick_setting(p));
			write_reg(REG_SNARE, pick_setting(p));
			write_reg(REG_HAT, pick_setting(p));
			write_reg(REG_MUTED, {6'($urandom_range(0, 63)), ((p == 4) ? 1'b1 : 1'b0)});
			if ($urandom_range(0, 1) == 0) write_reg(REG_NONE, 7'($urandom_range(0, 127)));
			cfg_valid <= 1'b0;

			// Mostly samples with score steps among them, with random content.
			done_items = 0;
			while (done_items < PHASE_ITEMS) begin
				it.op = ($urandom_range(0, 99) < 25) ? OP_LOAD : OP_SAMPLE;
				it.lead_kind = rand_kind();
				it.lead_inc = rand_inc();
				it.bass_kind = rand_kind();
				it.bass_inc = rand_inc();
				it.arp_kind = rand_kind();
				it.arp_inc = rand_inc();
				it.snare_hit = $urandom_range(0, 99) < 20;
				it.hat_hit = $urandom_range(0, 99) < 30;
				if (!(mute && it.op == OP_LOAD)) done_items++;
				send_item(it, 1'b0, 16'd0);
				if ($urandom_range(0, 199) == 0)
					drain_results(1'b0);
				else
					pause_input();
			end
		end

		drain_results(1'b1);
		if (expected_samples.size() != 0) begin
			$error("sample: %0d expected samples never arrived", expected_samples.size());
			fails++;
		end
		$display("Covered %0d score steps and %0d samples (%0d saturated) over %0d phases,",
			n_loads, n_samples, n_saturated, RAND_PHASES + 1);
		$display("with %0d register writes including muting, zero gain and full-scale weights.",
			n_writes);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
